FILE: hdl/rsts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsts_pkg;

	localparam int DEPTH  = 1024;
	localparam int ADDR_W = $clog2(DEPTH);
	// signed pointer range covers -1 .. DEPTH
	localparam int PTR_W  = ADDR_W + 2;
	localparam int LEN_W  = 11;
	localparam int IDX_W  = 10;
	localparam int POS_W  = 10;
	localparam int VAL_W  = 32;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic REG_LENGTH = 1'b0;
	localparam logic [LEN_W-1:0] LENGTH_RST = LEN_W'(1);

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SEARCH = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LAST,
		ST_PIV,
		ST_PIV_CMP,
		ST_SEL,
		ST_BS,
		ST_BS_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t                     op;
		logic [IDX_W-1:0]        index;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} res_t;

endpackage

`default_nettype wire

FILE: hdl/rsts_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rsts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: hdl/rotated_sorted_table_search_unit.sv
// channel   | handshake              | payload             | notes
// ----------+------------------------+---------------------+---------------------------
// command   | start & !busy          | cmd (op,index,value)| write or search word
// result    | done (one-cycle pulse) | result (found,pos)  | one word per search only
// config    | psel&penable&pwrite    | paddr, pwdata       | length at byte 0, pready=1
//
// A write does not make the unit busy; the next command can follow at once.
// A search holds busy through its result word. At 1024 entries it makes 10 pivot
// steps and up to 11 key steps; every bisection step is one table read plus one
// compare.
// Reset clears the controller and sets length to 1; the table is not cleared.
// The result receiver cannot stall; busy holds off commands during a search.
`timescale 1ns / 1ps
`default_nettype none

module rotated_sorted_table_search_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire rsts_pkg::cmd_t                cmd,
	output logic                               done,
	output rsts_pkg::res_t                     result,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [rsts_pkg::APB_AW-1:0]   paddr,
	input  wire logic [rsts_pkg::APB_DW-1:0]   pwdata,
	output logic      [rsts_pkg::APB_DW-1:0]   prdata,
	output logic                               pready
);

	localparam int AW = rsts_pkg::ADDR_W;
	localparam int PW = rsts_pkg::PTR_W;
	localparam int VW = rsts_pkg::VAL_W;

	rsts_pkg::state_t state_q, state_d;
	logic [rsts_pkg::LEN_W-1:0] len_q;

	logic signed [PW-1:0] lo_q, lo_d, hi_q, hi_d, n_q, n_d;
	logic signed [VW-1:0] key_q, key_d, vhi_q, vhi_d, vlast_q, vlast_d;
	logic [AW-1:0]        mid_q, mid_d;
	rsts_pkg::res_t       res_q, res_d;

	logic signed [PW-1:0] eff_n, mid, mid_ext;
	logic signed [VW-1:0] rd_val;

	logic                 ram_we;
	logic [AW-1:0]        ram_raddr;
	logic [VW-1:0]        ram_rdata;

	logic cfg_wr;

	rsts_ram #(
		.WIDTH(VW),
		.DEPTH(rsts_pkg::DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(cmd.index)),
		.wdata(cmd.value),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[2] == rsts_pkg::REG_LENGTH) ? rsts_pkg::APB_DW'(len_q) : '0;

	assign eff_n   = (32'(len_q) > rsts_pkg::DEPTH) ? PW'(rsts_pkg::DEPTH) : PW'(len_q);
	assign mid     = lo_q + ((hi_q - lo_q) >>> 1);
	assign mid_ext = {2'b00, mid_q};
	assign rd_val  = $signed(ram_rdata);

	assign busy   = (state_q != rsts_pkg::ST_IDLE);
	assign done   = (state_q == rsts_pkg::ST_DONE);
	assign result = res_q;

	always_comb begin
		state_d   = state_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		n_d       = n_q;
		key_d     = key_q;
		vhi_d     = vhi_q;
		vlast_d   = vlast_q;
		mid_d     = mid_q;
		res_d     = res_q;
		ram_we    = 1'b0;
		ram_raddr = mid[AW-1:0];
		case (state_q)
			rsts_pkg::ST_IDLE: begin
				if (start) begin
					if (cmd.op == rsts_pkg::OP_WRITE) begin
						ram_we = (32'(cmd.index) < rsts_pkg::DEPTH);
					end else begin
						key_d = cmd.value;
						n_d   = eff_n;
						lo_d  = '0;
						hi_d  = eff_n - PW'(1);
						ram_raddr = AW'(eff_n - PW'(1));
						if (eff_n == '0) begin
							res_d   = '0;
							state_d = rsts_pkg::ST_DONE;
						end else begin
							state_d = rsts_pkg::ST_LAST;
						end
					end
				end
			end
			rsts_pkg::ST_LAST: begin
				// last entry: initial hi value and upper bound of the right run
				vhi_d   = rd_val;
				vlast_d = rd_val;
				state_d = rsts_pkg::ST_PIV;
			end
			rsts_pkg::ST_PIV: begin
				if (lo_q < hi_q) begin
					mid_d   = mid[AW-1:0];
					state_d = rsts_pkg::ST_PIV_CMP;
				end else begin
					state_d = rsts_pkg::ST_SEL;
				end
			end
			rsts_pkg::ST_PIV_CMP: begin
				if (rd_val > vhi_q) begin
					lo_d = mid_ext + PW'(1);
				end else begin
					hi_d  = mid_ext;
					vhi_d = rd_val;
				end
				state_d = rsts_pkg::ST_PIV;
			end
			rsts_pkg::ST_SEL: begin
				// lo_q is the pivot, vhi_q holds its value
				if (key_q >= vhi_q && key_q <= vlast_q) begin
					hi_d = n_q - PW'(1);
				end else begin
					lo_d = '0;
					hi_d = lo_q - PW'(1);
				end
				state_d = rsts_pkg::ST_BS;
			end
			rsts_pkg::ST_BS: begin
				if (lo_q <= hi_q) begin
					mid_d   = mid[AW-1:0];
					state_d = rsts_pkg::ST_BS_CMP;
				end else begin
					res_d   = '0;
					state_d = rsts_pkg::ST_DONE;
				end
			end
			rsts_pkg::ST_BS_CMP: begin
				if (rd_val > key_q) begin
					hi_d    = mid_ext - PW'(1);
					state_d = rsts_pkg::ST_BS;
				end else if (rd_val < key_q) begin
					lo_d    = mid_ext + PW'(1);
					state_d = rsts_pkg::ST_BS;
				end else begin
					res_d.found    = 1'b1;
					res_d.position = rsts_pkg::POS_W'(mid_q);
					state_d        = rsts_pkg::ST_DONE;
				end
			end
			rsts_pkg::ST_DONE: begin
				state_d = rsts_pkg::ST_IDLE;
			end
			default: begin
				state_d = rsts_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsts_pkg::ST_IDLE;
			len_q   <= rsts_pkg::LENGTH_RST;
		end else begin
			state_q <= state_d;
			if (cfg_wr && paddr[2] == rsts_pkg::REG_LENGTH) begin
				len_q <= pwdata[rsts_pkg::LEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		n_q     <= n_d;
		key_q   <= key_d;
		vhi_q   <= vhi_d;
		vlast_q <= vlast_d;
		mid_q   <= mid_d;
		res_q   <= res_d;
	end

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result word outside a search");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result word held longer than one cycle");

	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.found) |-> (result.position == '0))
		else $error("miss with nonzero position");

	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.op == rsts_pkg::OP_SEARCH) |=> busy)
		else $error("search word did not start a search");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.op == rsts_pkg::OP_WRITE) |=> !busy)
		else $error("write word left the unit busy");

endmodule

`default_nettype wire
